>>> rtl/core/mit_pkg.sv
// ----------------------------------------------------------------------------
// mit_pkg
// Shared types and constants of the irreducibility test block: beat payloads,
// the queued load command and the command queue status.
// ----------------------------------------------------------------------------
package mit_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned CSR_W       = 5;
   localparam int unsigned IDX_W       = 4;
   localparam int unsigned SUBSET_W    = 16;

   typedef struct packed {
      logic [IDX_W-1:0]  row_index;
      logic [IDX_W-1:0]  column_index;
      logic signed [31:0] entry_value;
      logic              last_entry;
   } req_type;

   typedef struct packed {
      logic                irreducible;
      logic [SUBSET_W-1:0] invariant_subset;
      logic [IDX_W-1:0]    witness_node;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             nonzero;
      logic             write;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

>>> rtl/core/mit_front.sv
// ----------------------------------------------------------------------------
// mit_front
// Accepts entry beats and classifies them into load commands for the queue:
// in-range check against the size in use, nonzero mark and last flag.
// ----------------------------------------------------------------------------
module mit_front #(
   parameter int unsigned MAX_SIZE = 16
) (
   input  logic                            start,
   output logic                            busy,
   input  mit_pkg::req_type                req_data,
   input  logic [$clog2(MAX_SIZE+1)-1:0]   size_in_use,
   input  mit_pkg::q_status_type           q_status,
   output logic                            push,
   output mit_pkg::cmd_type                push_cmd
);

   localparam int unsigned NW   = $clog2(MAX_SIZE + 1);
   localparam int unsigned CMPW = (NW > mit_pkg::IDX_W) ? NW : mit_pkg::IDX_W;

   logic row_ok;
   logic col_ok;

   assign row_ok = CMPW'(req_data.row_index) < CMPW'(size_in_use);
   assign col_ok = CMPW'(req_data.column_index) < CMPW'(size_in_use);

   assign busy = q_status.full;
   assign push = start && !busy;

   always_comb begin
      push_cmd.row     = req_data.row_index;
      push_cmd.col     = req_data.column_index;
      push_cmd.nonzero = (req_data.entry_value != 32'sd0);
      push_cmd.write   = row_ok && col_ok;
      push_cmd.last    = req_data.last_entry;
   end

endmodule

>>> rtl/core/mit_queue.sv
// ----------------------------------------------------------------------------
// mit_queue
// Small command queue between the front and the back end.
// ----------------------------------------------------------------------------
module mit_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mit_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output mit_pkg::cmd_type      head,
   output mit_pkg::q_status_type status
);

   mit_pkg::cmd_type                  entries_ff [mit_pkg::QUEUE_DEPTH];
   logic [mit_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [mit_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [mit_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [mit_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [mit_pkg::QPTR_W:0]          count_ff;
   logic [mit_pkg::QPTR_W:0]          count_in;
   logic                              do_push;
   logic                              do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (mit_pkg::QPTR_W+1)'(mit_pkg::QUEUE_DEPTH));
   assign head         = entries_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/mit_back.sv
// ----------------------------------------------------------------------------
// mit_back
// Executes load commands on the column store and, on the last entry, walks
// each start node's reachable set one column per cycle to test irreducibility.
// ----------------------------------------------------------------------------
module mit_back #(
   parameter int unsigned MAX_SIZE = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(MAX_SIZE+1)-1:0]   size_in_use,
   input  mit_pkg::cmd_type                head,
   input  mit_pkg::q_status_type           q_status,
   output logic                            pop,
   output logic                            rsp_strobe,
   output mit_pkg::rsp_type                rsp_data
);

   localparam int unsigned NW = $clog2(MAX_SIZE + 1);
   localparam int unsigned AW = $clog2(MAX_SIZE);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_CHECK
   } state_type;

   logic [MAX_SIZE-1:0] mem [MAX_SIZE];

   state_type           state_ff,      state_in;
   mit_pkg::cmd_type    cmd_ff,        cmd_in;
   logic [AW-1:0]       s_ff,          s_in;
   logic [AW-1:0]       j_ff,          j_in;
   logic [MAX_SIZE-1:0] reached_ff,    reached_in;
   logic [MAX_SIZE-1:0] frontier_ff,   frontier_in;
   logic [MAX_SIZE-1:0] next_ff,       next_in;
   logic                take_ff,       take_in;
   logic [MAX_SIZE-1:0] col_valid_ff,  col_valid_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   mit_pkg::rsp_type    rsp_ff,        rsp_in;
   logic [MAX_SIZE-1:0] rd_data_ff;
   logic                rd_valid_ff;

   logic [AW-1:0]       rd_addr;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [MAX_SIZE-1:0] mem_wdata;
   logic [MAX_SIZE-1:0] all_mask;
   logic [MAX_SIZE-1:0] below_mask;
   logic [MAX_SIZE-1:0] acc;
   logic [MAX_SIZE-1:0] cur_word;
   logic [MAX_SIZE-1:0] row_bit;
   logic [MAX_SIZE-1:0] new_front;
   logic                found;
   logic                last_start;
   logic                last_col;

   always_comb begin
      for (int i = 0; i < MAX_SIZE; i++) begin
         all_mask[i]   = NW'(i) < size_in_use;
         below_mask[i] = NW'(i) < NW'(s_ff);
      end
   end

   assign acc        = next_ff | ((take_ff && rd_valid_ff) ? (rd_data_ff & all_mask) : '0);
   assign cur_word   = rd_valid_ff ? rd_data_ff : '0;
   assign row_bit    = MAX_SIZE'(1) << cmd_ff.row;
   assign new_front  = acc & ~reached_ff;
   assign last_start = NW'(s_ff) == (size_in_use - NW'(1));
   assign last_col   = NW'(j_ff) == (size_in_use - NW'(1));
   assign found      = (s_ff == '0) ? (reached_ff != all_mask)
                                    : ((reached_ff & below_mask) == '0);

   assign pop        = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      rd_addr = AW'(cmd_ff.col);
      if (state_ff == ST_IDLE) begin
         rd_addr = AW'(head.col);
      end else if (state_ff == ST_SCAN) begin
         rd_addr = j_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      s_in          = s_ff;
      j_in          = j_ff;
      reached_in    = reached_ff;
      frontier_in   = frontier_ff;
      next_in       = next_ff;
      take_in       = 1'b0;
      col_valid_in  = col_valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = AW'(cmd_ff.col);
      mem_wdata     = cmd_ff.nonzero ? (cur_word | row_bit) : (cur_word & ~row_bit);

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               cmd_in = head;
               if (head.write) begin
                  state_in = ST_LOAD;
               end else if (head.last) begin
                  s_in     = '0;
                  state_in = ST_START;
               end
            end
         end
         ST_LOAD: begin
            mem_we                          = 1'b1;
            col_valid_in[AW'(cmd_ff.col)]   = 1'b1;
            if (cmd_ff.last) begin
               s_in     = '0;
               state_in = ST_START;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_START: begin
            reached_in  = MAX_SIZE'(1) << s_ff;
            frontier_in = MAX_SIZE'(1) << s_ff;
            next_in     = '0;
            j_in        = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            next_in = acc;
            take_in = frontier_ff[j_ff];
            j_in    = j_ff + 1'b1;
            if (last_col) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (new_front == '0) begin
               state_in = ST_CHECK;
            end else begin
               reached_in  = reached_ff | new_front;
               frontier_in = new_front;
               next_in     = '0;
               j_in        = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_CHECK: begin
            if (found || last_start) begin
               rsp_strobe_in           = 1'b1;
               rsp_in.irreducible      = !found;
               rsp_in.invariant_subset = found ? mit_pkg::SUBSET_W'(reached_ff) : '0;
               rsp_in.witness_node     = found ? mit_pkg::IDX_W'(s_ff) : '0;
               col_valid_in            = '0;
               state_in                = ST_IDLE;
            end else begin
               s_in     = s_ff + 1'b1;
               state_in = ST_START;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
         take_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_valid_ff  <= col_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         take_ff       <= take_in;
      end
      cmd_ff      <= cmd_in;
      s_ff        <= s_in;
      j_ff        <= j_in;
      reached_ff  <= reached_in;
      frontier_ff <= frontier_in;
      next_ff     <= next_in;
      rsp_ff      <= rsp_in;
   end

   // column store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= col_valid_ff[rd_addr];
   end

endmodule

>>> rtl/core/matrix_irreducibility_test.sv
// ----------------------------------------------------------------------------
// matrix_irreducibility_test
// Loads a square matrix one entry per beat as nonzero marks and tests whether
// it is irreducible, reporting an invariant subset and witness start node.
// ----------------------------------------------------------------------------
// Entry beats are taken whenever busy is low and go through a four-deep
// command queue; the back end stores each entry as a read then a write of
// one column word, so busy rises during long loads. On the beat marked last
// the test runs: for each start node it walks all n columns of the store,
// one per cycle, for every growth round, where n is the size in use. Beats
// after the last one are queued and loaded once the result is out. The
// result is shown on rsp_data for a single cycle with rsp_strobe high and
// cannot be held off.
// Write csr_write_data only while the block is idle.
// ----------------------------------------------------------------------------
module matrix_irreducibility_test #(
   parameter int unsigned MAX_SIZE = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  mit_pkg::req_type              req_data,
   output logic                          rsp_strobe,
   output mit_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_enable,
   input  logic [mit_pkg::CSR_W-1:0]     csr_write_data
);

   localparam int unsigned NW = $clog2(MAX_SIZE + 1);
   localparam int unsigned CW = (NW > mit_pkg::CSR_W) ? NW : mit_pkg::CSR_W;

   logic [mit_pkg::CSR_W-1:0] csr_size_ff;
   logic [mit_pkg::CSR_W-1:0] csr_size_in;
   logic [CW-1:0]             size_raw;
   logic [NW-1:0]             size_in_use;
   logic                      push;
   logic                      pop;
   mit_pkg::cmd_type          push_cmd;
   mit_pkg::cmd_type          head;
   mit_pkg::q_status_type     q_status;

   assign csr_size_in = csr_write_enable ? csr_write_data : csr_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_size_ff <= mit_pkg::CSR_W'(16);
      end else begin
         csr_size_ff <= csr_size_in;
      end
   end

   assign size_raw = CW'(csr_size_ff);

   always_comb begin
      if (size_raw == '0) begin
         size_in_use = NW'(1);
      end else if (size_raw > CW'(MAX_SIZE)) begin
         size_in_use = NW'(MAX_SIZE);
      end else begin
         size_in_use = NW'(size_raw);
      end
   end

   mit_front #(
      .MAX_SIZE (MAX_SIZE)
   ) u_front (
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .size_in_use (size_in_use),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   mit_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   mit_back #(
      .MAX_SIZE (MAX_SIZE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .size_in_use (size_in_use),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

>>> bench/matrix_irreducibility_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_irreducibility_test_tb
// Loads matrices entry by entry through the start/busy port and checks each
// irreducibility verdict against an in-bench reachability predictor. Covers
// size extremes, out-of-range and rewritten entries, size changes between
// loads, and random rings, split and sparse graphs with random idling.
// ----------------------------------------------------------------------------
module matrix_irreducibility_test_tb;

   localparam int MAX_NODES = 16;
   localparam int RANDOM_BEATS = 1800;

   typedef enum int {RING, SPARSE, SPLIT, BROKEN} shape_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   mit_pkg::req_type req_data = '0;
   logic rsp_strobe;
   mit_pkg::rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [mit_pkg::CSR_W-1:0] csr_write_data = '0;

   mit_pkg::req_type entry_beats[$];
   mit_pkg::rsp_type pending_verdicts[$];

   logic [MAX_NODES-1:0] adjacency [MAX_NODES];
   logic [mit_pkg::CSR_W-1:0] size_setting = 5'd16;

   int cycle_count = 0;
   int cycle_budget = 0;
   int accepted_beats = 0;
   int popped_beats = 0;
   int queued_beats = 0;
   int results_checked = 0;
   int size_writes = 0;
   int errors = 0;
   int mismatch_count = 0;

   matrix_irreducibility_test dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      for (int j = 0; j < MAX_NODES; j++) begin
         adjacency[j] = '0;
      end
   end

   function automatic int nodes_in_use();
      int n;
      n = size_setting;
      if (n == 0) n = 1;
      if (n > MAX_NODES) n = MAX_NODES;
      return n;
   endfunction

   function automatic logic [MAX_NODES-1:0] low_mask(input int n);
      logic [31:0] m;
      m = (32'd1 << n) - 32'd1;
      return m[MAX_NODES-1:0];
   endfunction

   // stores one entry; on the last one runs the reachability search
   function automatic bit load_entry(input mit_pkg::req_type beat,
                                     output mit_pkg::rsp_type verdict);
      int n;
      int s;
      logic [MAX_NODES-1:0] all_nodes;
      logic [MAX_NODES-1:0] reached;
      logic [MAX_NODES-1:0] frontier;
      logic [MAX_NODES-1:0] grown;
      bit found;
      n = nodes_in_use();
      all_nodes = low_mask(n);
      found = 1'b0;
      verdict = '0;
      verdict.irreducible = 1'b1;
      if (beat.row_index < n && beat.column_index < n) begin
         adjacency[beat.column_index][beat.row_index] = (beat.entry_value != 0);
      end
      if (!beat.last_entry) return 1'b0;
      for (s = 0; s < n && !found; s++) begin
         reached = '0;
         reached[s] = 1'b1;
         frontier = reached;
         while (frontier != '0) begin
            grown = '0;
            for (int j = 0; j < n; j++) begin
               if (frontier[j]) grown |= adjacency[j] & all_nodes;
            end
            frontier = grown & ~reached;
            reached |= frontier;
         end
         if (s > 0 ? (reached & low_mask(s)) == '0 : reached != all_nodes) begin
            found = 1'b1;
            verdict.irreducible = 1'b0;
            verdict.invariant_subset = reached;
            verdict.witness_node = s[mit_pkg::IDX_W-1:0];
         end
      end
      for (int j = 0; j < MAX_NODES; j++) begin
         adjacency[j] = '0;
      end
      return 1'b1;
   endfunction

   task automatic note_mismatch(input string field, input int want, input int got);
      errors++;
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch on %s: expected %0h, got %0h", field, want, got);
      end
   endtask

   // driver: holds a beat until taken, idles at random outside quiet windows
   always @(negedge clock) begin : driver
      bit took;
      bit idle;
      took = (accepted_beats != popped_beats);
      idle = ($urandom_range(99) < 13) && (((cycle_count >> 11) % 4) != 3);
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (took) begin
            void'(entry_beats.pop_front());
            popped_beats++;
         end
         if (start && !took) begin
            start <= 1'b1;
         end else if (entry_beats.size() != 0 && !idle) begin
            start <= 1'b1;
            req_data <= entry_beats[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: checks result beats, predicts on accepted entry beats
   always @(posedge clock) begin : monitor
      mit_pkg::rsp_type want;
      mit_pkg::rsp_type verdict;
      if (!reset) begin
         if (rsp_strobe) begin
            results_checked++;
            if (pending_verdicts.size() == 0) begin
               errors++;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result beat with none expected: %0h", rsp_data);
               end
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_data.irreducible !== want.irreducible)
                  note_mismatch("irreducible", want.irreducible, rsp_data.irreducible);
               if (rsp_data.invariant_subset !== want.invariant_subset)
                  note_mismatch("invariant_subset", want.invariant_subset,
                                rsp_data.invariant_subset);
               if (rsp_data.witness_node !== want.witness_node)
                  note_mismatch("witness_node", want.witness_node, rsp_data.witness_node);
            end
         end
         if (start && !busy) begin
            accepted_beats++;
            if (load_entry(req_data, verdict)) pending_verdicts.push_back(verdict);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 4 * cycle_budget + 20000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic queue_entry(input int row, input int col, input int value, input bit last);
      mit_pkg::req_type beat;
      int n;
      n = nodes_in_use();
      beat.row_index = row[mit_pkg::IDX_W-1:0];
      beat.column_index = col[mit_pkg::IDX_W-1:0];
      beat.entry_value = value;
      beat.last_entry = last;
      entry_beats.push_back(beat);
      queued_beats++;
      cycle_budget += 4;
      if (last) cycle_budget += n * (n * (n + 1) + 2) + 40;
   endtask

   function automatic int nonzero_value();
      int v;
      v = $urandom;
      if (v == 0) v = 1;
      return v;
   endfunction

   task automatic queue_edge(input int from, input int to);
      queue_entry(to, from, nonzero_value(), 1'b0);
   endtask

   task automatic settle();
      while (entry_beats.size() != 0 || start || pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_size(input int value);
      settle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value[mit_pkg::CSR_W-1:0];
      size_setting = value[mit_pkg::CSR_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      size_writes++;
      cycle_budget += 100;
   endtask

   task automatic queue_matrix(input shape_type shape, input bit close_out);
      int n;
      int split;
      int k;
      int swap;
      int order [MAX_NODES];
      n = nodes_in_use();
      for (int i = 0; i < MAX_NODES; i++) order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
         k = $urandom_range(i);
         swap = order[i];
         order[i] = order[k];
         order[k] = swap;
      end
      if (shape == SPLIT && n > 1) begin
         // first part closed, second part may feed into it
         split = $urandom_range(1, n - 1);
         for (int i = 0; i < split; i++) queue_edge(order[i], order[(i + 1) % split]);
         for (int i = split; i < n; i++)
            queue_edge(order[i], order[split + (i + 1 - split) % (n - split)]);
         k = $urandom_range(n);
         for (int i = 0; i < k; i++)
            queue_edge(order[$urandom_range(split, n - 1)], order[$urandom_range(n - 1)]);
      end else if (shape == SPARSE) begin
         k = $urandom_range(2 * n);
         for (int i = 0; i < k; i++) queue_edge($urandom_range(n - 1), $urandom_range(n - 1));
      end else begin
         for (int i = 0; i < n; i++) queue_edge(order[i], order[(i + 1) % n]);
         k = $urandom_range(n);
         for (int i = 0; i < k; i++) queue_edge($urandom_range(n - 1), $urandom_range(n - 1));
         if (shape == BROKEN) begin
            k = $urandom_range(n - 1);
            queue_entry(order[(k + 1) % n], order[k], 0, 1'b0);
         end
      end
      if ($urandom_range(3) == 0) begin
         k = $urandom_range(1, 3);
         for (int i = 0; i < k; i++) begin
            if (n < MAX_NODES && $urandom_range(1))
               queue_entry($urandom_range(n, 15), $urandom_range(15), nonzero_value(), 1'b0);
            else if (n < MAX_NODES)
               queue_entry($urandom_range(15), $urandom_range(n, 15), nonzero_value(), 1'b0);
            else
               queue_entry($urandom_range(n - 1), $urandom_range(n - 1), 0, 1'b0);
         end
      end
      if (close_out) begin
         case ($urandom_range(2))
            0: queue_entry($urandom_range(n - 1), $urandom_range(n - 1), 0, 1'b1);
            1: queue_entry($urandom_range(n - 1), $urandom_range(n - 1), $urandom, 1'b1);
            default: queue_entry($urandom_range(15), $urandom_range(15), $urandom, 1'b1);
         endcase
      end
   endtask

   initial begin : stimulus
      int directed_beats;
      int pick;
      int matrices;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      cycle_budget += 100;

      // default size, highest corner entries, empty graph from node 0
      queue_entry(15, 15, 2147483647, 1'b0);
      queue_entry(0, 15, -2147483647 - 1, 1'b1);

      // three-node ring with ignored out-of-range entries
      write_size(3);
      queue_entry(1, 0, 2147483647, 1'b0);
      queue_entry(2, 1, -2147483647 - 1, 1'b0);
      queue_entry(0, 2, 1, 1'b0);
      queue_entry(15, 0, 5, 1'b0);
      queue_entry(0, 3, 9, 1'b0);
      queue_entry(2, 2, 0, 1'b1);

      // ring broken by a zero rewrite
      queue_entry(1, 0, 3, 1'b0);
      queue_entry(2, 1, 4, 1'b0);
      queue_entry(0, 2, 5, 1'b0);
      queue_entry(2, 1, 0, 1'b0);
      queue_entry(1, 0, -1, 1'b1);

      // size zero acts as one, oversized acts as sixteen
      write_size(0);
      queue_entry(0, 0, 0, 1'b1);
      queue_entry(0, 0, 7, 1'b1);
      write_size(31);
      queue_entry(15, 0, 0, 1'b1);

      // entries loaded at a larger size, then tested at a smaller one
      write_size(8);
      queue_entry(5, 6, 3, 1'b0);
      queue_entry(7, 5, 4, 1'b0);
      queue_entry(6, 7, 2, 1'b0);
      write_size(4);
      queue_entry(1, 0, 1, 1'b1);
      directed_beats = queued_beats;

      while (queued_beats < directed_beats + RANDOM_BEATS) begin
         pick = $urandom_range(99);
         if (pick < 5) write_size(0);
         else if (pick < 10) write_size($urandom_range(17, 31));
         else if (pick < 15) write_size(16);
         else if (pick < 25) write_size($urandom_range(9, 15));
         else if (pick < 30) write_size(1);
         else write_size($urandom_range(2, 8));
         matrices = $urandom_range(1, 4);
         for (int m = 0; m < matrices; m++) begin
            queue_matrix(shape_type'($urandom_range(3)),
                         !(m == matrices - 1 && $urandom_range(5) == 0));
         end
      end

      settle();
      errors += pending_verdicts.size();
      $display("covered %0d entry beats and %0d verdicts over %0d size settings",
               accepted_beats, results_checked, size_writes);
      $display("including ring, split, sparse and broken graphs plus out-of-range noise");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
